// ===== rtl/hsvr_pkg.sv =====
package hsvr_pkg;

   localparam int ChanWidth = 8;
   localparam int PipeDepth = 4;

   // hue interpolation factors: 256/3 and 2*256/3
   localparam logic [7:0] ThirdScale    = 8'(256 / 3);
   localparam logic [7:0] TwoThirdScale = 8'((256 * 2) / 3);

   typedef enum logic [1:0] {
      CSR_STRONG_YELLOW = 2'd0,
      CSR_HALVE_GREEN   = 2'd1,
      CSR_GREEN_SCALE   = 2'd2
   } csr_index_type;

   typedef logic [ChanWidth-1:0] chan_type;

   // (i * (1 + s)) >> 8
   function automatic chan_type scale_byte(input chan_type i, input chan_type s);
      logic [15:0] prod;
      prod = 16'(i) * (16'(s) + 16'd1);
      return prod[15:8];
   endfunction

   // ((i * s) >> 8) + 1 when both nonzero
   function automatic chan_type scale_video(input chan_type i, input chan_type s);
      logic [15:0] prod;
      logic        bump;
      prod = 16'(i) * 16'(s);
      bump = (i != '0) && (s != '0);
      return prod[15:8] + chan_type'(bump);
   endfunction

endpackage

// ===== rtl/hsv_to_rgb_rainbow.sv =====
// Channel   Ports                                  Handshake
// --------  -------------------------------------  ----------------------------
// request   req_hue, req_saturation, req_brightness start high, busy low
// result    rsp_red, rsp_green, rsp_blue           rsp_valid, one cycle only
// config    csr_index, csr_wdata                   csr_we, no wait
//
// Four register stages; a request taken at one edge shows its result once it has
// passed all four, and a new request may enter on every cycle (busy stays low).
// Stage 1: hue map and the two self-scaling multiplies (desat, dim level).
// Stage 2: green halving and green video scaling.
// Stage 3: desaturation toward white.  Stage 4: value dimming.
// Synchronous reset clears the stage valid bits and the config registers.
// The receiver cannot stall, so the pipe never holds.
module hsv_to_rgb_rainbow (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hsvr_pkg::chan_type   req_hue,
   input  hsvr_pkg::chan_type   req_saturation,
   input  hsvr_pkg::chan_type   req_brightness,
   output logic                 rsp_valid,
   output hsvr_pkg::chan_type   rsp_red,
   output hsvr_pkg::chan_type   rsp_green,
   output hsvr_pkg::chan_type   rsp_blue,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  hsvr_pkg::chan_type   csr_wdata
);
   import hsvr_pkg::*;

   // ---------------- config registers ----------------
   logic     strong_yellow_ff;
   logic     halve_green_ff;
   chan_type green_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strong_yellow_ff <= 1'b0;
         halve_green_ff   <= 1'b0;
         green_scale_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRONG_YELLOW: strong_yellow_ff <= csr_wdata[0];
            CSR_HALVE_GREEN:   halve_green_ff   <= csr_wdata[0];
            CSR_GREEN_SCALE:   green_scale_ff   <= csr_wdata;
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   // pipeline never back-pressures
   assign busy = 1'b0;

   // ---------------- valid chain ----------------
   logic [PipeDepth-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[PipeDepth-2:0], start};
      end
   end

   // ---------------- stage 1: hue map ----------------
   chan_type offset8;
   chan_type third;
   chan_type twothirds;
   chan_type r1_in, g1_in, b1_in;
   chan_type inv_sat;

   always_comb begin
      offset8   = {req_hue[4:0], 3'b000};
      third     = scale_byte(offset8, ThirdScale);
      twothirds = scale_byte(offset8, TwoThirdScale);
      inv_sat   = 8'd255 - req_saturation;
      r1_in = '0;
      g1_in = '0;
      b1_in = '0;
      unique case (req_hue[7:5])
         3'd0: begin
            r1_in = 8'd255 - third;
            g1_in = third;
         end
         3'd1: begin
            if (strong_yellow_ff) begin
               r1_in = 8'd170 + third;
               g1_in = 8'd85 + twothirds;
            end else begin
               r1_in = 8'd171;
               g1_in = 8'd85 + third;
            end
         end
         3'd2: begin
            if (strong_yellow_ff) begin
               r1_in = 8'd255 - offset8;
               g1_in = 8'd255;
            end else begin
               r1_in = 8'd171 - twothirds;
               g1_in = 8'd170 + third;
            end
         end
         3'd3: begin
            g1_in = 8'd255 - third;
            b1_in = third;
         end
         3'd4: begin
            g1_in = 8'd171 - twothirds;
            b1_in = 8'd85 + twothirds;
         end
         3'd5: begin
            r1_in = third;
            b1_in = 8'd255 - third;
         end
         3'd6: begin
            r1_in = 8'd85 + third;
            b1_in = 8'd171 - third;
         end
         3'd7: begin
            r1_in = 8'd170 + third;
            b1_in = 8'd85 - third;
         end
      endcase
   end

   chan_type r1_ff, g1_ff, b1_ff;
   chan_type desat1_ff;          // video(255-sat, 255-sat)
   chan_type dim1_ff;            // video(val, val)
   logic     sat_full1_ff, sat_zero1_ff, val_full1_ff;

   always_ff @(posedge clock) begin
      r1_ff        <= r1_in;
      g1_ff        <= g1_in;
      b1_ff        <= b1_in;
      desat1_ff    <= scale_video(inv_sat, inv_sat);
      dim1_ff      <= scale_video(req_brightness, req_brightness);
      sat_full1_ff <= (req_saturation == 8'd255);
      sat_zero1_ff <= (req_saturation == 8'd0);
      val_full1_ff <= (req_brightness == 8'd255);
   end

   // ---------------- stage 2: green adjust ----------------
   chan_type g_half;
   chan_type g2_in;

   always_comb begin
      g_half = halve_green_ff ? {1'b0, g1_ff[7:1]} : g1_ff;
      g2_in  = (green_scale_ff != '0) ? scale_video(g_half, green_scale_ff) : g_half;
   end

   chan_type r2_ff, g2_ff, b2_ff;
   chan_type desat2_ff, dim2_ff;
   logic     sat_full2_ff, sat_zero2_ff, val_full2_ff;

   always_ff @(posedge clock) begin
      r2_ff        <= r1_ff;
      g2_ff        <= g2_in;
      b2_ff        <= b1_ff;
      desat2_ff    <= desat1_ff;
      dim2_ff      <= dim1_ff;
      sat_full2_ff <= sat_full1_ff;
      sat_zero2_ff <= sat_zero1_ff;
      val_full2_ff <= val_full1_ff;
   end

   // ---------------- stage 3: desaturate ----------------
   chan_type keep;
   chan_type r3_in, g3_in, b3_in;

   always_comb begin
      keep = 8'd255 - desat2_ff;
      priority if (sat_full2_ff) begin
         r3_in = r2_ff;
         g3_in = g2_ff;
         b3_in = b2_ff;
      end else if (sat_zero2_ff) begin
         r3_in = 8'd255;
         g3_in = 8'd255;
         b3_in = 8'd255;
      end else begin
         // sum wraps at 8 bits
         r3_in = scale_byte(r2_ff, keep) + desat2_ff;
         g3_in = scale_byte(g2_ff, keep) + desat2_ff;
         b3_in = scale_byte(b2_ff, keep) + desat2_ff;
      end
   end

   chan_type r3_ff, g3_ff, b3_ff;
   chan_type dim3_ff;
   logic     val_full3_ff;

   always_ff @(posedge clock) begin
      r3_ff        <= r3_in;
      g3_ff        <= g3_in;
      b3_ff        <= b3_in;
      dim3_ff      <= dim2_ff;
      val_full3_ff <= val_full2_ff;
   end

   // ---------------- stage 4: dim ----------------
   chan_type r4_in, g4_in, b4_in;

   always_comb begin
      priority if (val_full3_ff) begin
         r4_in = r3_ff;
         g4_in = g3_ff;
         b4_in = b3_ff;
      end else if (dim3_ff == '0) begin
         r4_in = '0;
         g4_in = '0;
         b4_in = '0;
      end else begin
         r4_in = scale_byte(r3_ff, dim3_ff);
         g4_in = scale_byte(g3_ff, dim3_ff);
         b4_in = scale_byte(b3_ff, dim3_ff);
      end
   end

   chan_type r4_ff, g4_ff, b4_ff;

   always_ff @(posedge clock) begin
      r4_ff <= r4_in;
      g4_ff <= g4_in;
      b4_ff <= b4_in;
   end

   assign rsp_valid = valid_ff[PipeDepth-1];
   assign rsp_red   = r4_ff;
   assign rsp_green = g4_ff;
   assign rsp_blue  = b4_ff;

endmodule

// ===== rtl/hsvr_checker.sv =====
module hsvr_props (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input hsvr_pkg::chan_type req_saturation,
   input hsvr_pkg::chan_type req_brightness,
   input logic               rsp_valid,
   input hsvr_pkg::chan_type rsp_red,
   input hsvr_pkg::chan_type rsp_green,
   input hsvr_pkg::chan_type rsp_blue
);
   import hsvr_pkg::*;

   // one result per request, fixed latency, nothing left over from reset
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == ($past(start, PipeDepth) && !$past(reset, 4) && !$past(reset, 3)
                    && !$past(reset, 2) && !$past(reset, 1)))
      else $error("result strobe does not match request four cycles back");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   // zero brightness gives black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_brightness, PipeDepth) == 8'd0)
      |-> (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
      else $error("zero brightness did not give black");

   // no saturation at full brightness gives white
   a_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_saturation, PipeDepth) == 8'd0
       && $past(req_brightness, PipeDepth) == 8'd255)
      |-> (rsp_red == 8'd255 && rsp_green == 8'd255 && rsp_blue == 8'd255))
      else $error("zero saturation did not give white");

endmodule

bind hsv_to_rgb_rainbow hsvr_props u_hsvr_props (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_saturation (req_saturation),
   .req_brightness (req_brightness),
   .rsp_valid      (rsp_valid),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue)
);

// ===== sim/hsvr_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register channels of the rainbow converter,
// predicts every pixel and checks the results in order.
module hsvr_checker
   import hsvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  chan_type req_hue,
   input  chan_type req_saturation,
   input  chan_type req_brightness,
   input  logic     rsp_valid,
   input  chan_type rsp_red,
   input  chan_type rsp_green,
   input  chan_type rsp_blue,
   input  logic     csr_we,
   input  logic [1:0] csr_index,
   input  chan_type csr_wdata,
   output int       error_count,
   output int       pending_count,
   output int       pixel_count
);

   localparam int ReportLimit = 10;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_pixel_t;

   // hue bits 7..5
   typedef enum logic [2:0] {
      HUE_RED, HUE_ORANGE, HUE_YELLOW, HUE_GREEN,
      HUE_AQUA, HUE_BLUE, HUE_PURPLE, HUE_PINK
   } hue_sector_e;

   rgb_pixel_t expected_pixels[$];
   logic       strong_yellow_q;
   logic       halve_green_q;
   chan_type   green_scale_q;
   int         fault_total;
   int         checked_total;

   // (i * (s + 1)) >> 8
   function automatic chan_type fixed_scale(input chan_type i, input chan_type s);
      logic [15:0] prod;
      prod = {8'd0, i} * ({8'd0, s} + 16'd1);
      return prod[15:8];
   endfunction

   // (i * s) >> 8, plus one when neither factor is zero
   function automatic chan_type video_scale(input chan_type i, input chan_type s);
      logic [15:0] prod;
      chan_type    res;
      prod = {8'd0, i} * {8'd0, s};
      res  = prod[15:8];
      if (i != 8'd0 && s != 8'd0) res = res + 8'd1;
      return res;
   endfunction

   function automatic rgb_pixel_t rainbow_pixel(input chan_type hue, input chan_type sat,
                                                input chan_type val);
      chan_type offs8, third, two_thirds, r, g, b, desat, keep, dim;
      offs8      = {hue[4:0], 3'b000};
      third      = fixed_scale(offs8, ThirdScale);
      two_thirds = fixed_scale(offs8, TwoThirdScale);
      b          = 8'd0;
      case (hue_sector_e'(hue[7:5]))
         HUE_RED: begin
            r = 8'd255 - third;  g = third;
         end
         HUE_ORANGE: begin
            if (strong_yellow_q) begin
               r = 8'd170 + third;  g = 8'd85 + two_thirds;
            end else begin
               r = 8'd171;  g = 8'd85 + third;
            end
         end
         HUE_YELLOW: begin
            if (strong_yellow_q) begin
               r = 8'd255 - offs8;  g = 8'd255;
            end else begin
               r = 8'd171 - two_thirds;  g = 8'd170 + third;
            end
         end
         HUE_GREEN: begin
            r = 8'd0;  g = 8'd255 - third;  b = third;
         end
         HUE_AQUA: begin
            r = 8'd0;  g = 8'd171 - two_thirds;  b = 8'd85 + two_thirds;
         end
         HUE_BLUE: begin
            r = third;  g = 8'd0;  b = 8'd255 - third;
         end
         HUE_PURPLE: begin
            r = 8'd85 + third;  g = 8'd0;  b = 8'd171 - third;
         end
         default: begin
            r = 8'd170 + third;  g = 8'd0;  b = 8'd85 - third;
         end
      endcase

      if (halve_green_q) g = g >> 1;
      if (green_scale_q != 8'd0) g = video_scale(g, green_scale_q);

      if (sat == 8'd0) begin
         r = 8'd255;  g = 8'd255;  b = 8'd255;
      end else if (sat != 8'd255) begin
         desat = video_scale(8'd255 - sat, 8'd255 - sat);
         keep  = 8'd255 - desat;
         r     = fixed_scale(r, keep) + desat;
         g     = fixed_scale(g, keep) + desat;
         b     = fixed_scale(b, keep) + desat;
      end

      if (val != 8'd255) begin
         dim = video_scale(val, val);
         r   = (dim == 8'd0) ? 8'd0 : fixed_scale(r, dim);
         g   = (dim == 8'd0) ? 8'd0 : fixed_scale(g, dim);
         b   = (dim == 8'd0) ? 8'd0 : fixed_scale(b, dim);
      end
      return {r, g, b};
   endfunction

   task automatic log_fault(input string msg);
      fault_total++;
      if (fault_total <= ReportLimit) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rgb_pixel_t got;
      rgb_pixel_t want;
      if (reset) begin
         expected_pixels.delete();
         strong_yellow_q = 1'b0;
         halve_green_q   = 1'b0;
         green_scale_q   = 8'd0;
         fault_total     = 0;
         checked_total   = 0;
      end else begin
         if (rsp_valid) begin
            got = {rsp_red, rsp_green, rsp_blue};
            if (expected_pixels.size() == 0) begin
               log_fault($sformatf("result r=%0d g=%0d b=%0d with no request outstanding",
                                   got.red, got.green, got.blue));
            end else begin
               want = expected_pixels.pop_front();
               checked_total++;
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue)
                  log_fault($sformatf("pixel %0d: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                      checked_total, want.red, want.green, want.blue,
                                      got.red, got.green, got.blue));
            end
         end
         if (start && !busy)
            expected_pixels.push_back(rainbow_pixel(req_hue, req_saturation, req_brightness));
         if (csr_we) begin
            case (csr_index)
               CSR_STRONG_YELLOW: strong_yellow_q = csr_wdata[0];
               CSR_HALVE_GREEN:   halve_green_q   = csr_wdata[0];
               CSR_GREEN_SCALE:   green_scale_q   = csr_wdata;
               default: ;
            endcase
         end
      end
      error_count   <= fault_total;
      pending_count <= expected_pixels.size();
      pixel_count   <= checked_total;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Rainbow HSV to RGB converter testbench.
// The top only produces stimulus and prints the verdict; hsvr_checker sits
// beside the block, predicts each pixel and compares the results.
module tb_top;
   import hsvr_pkg::*;

   localparam int ResetCycles   = 12;
   localparam int RandomPhases  = 7;
   localparam int PhaseItems    = 186;          // about 1300 random requests in all
   localparam int MaxGap        = 40;
   localparam int DrainCycles   = PipeDepth + 4;
   localparam int WatchdogLimit = 2000;
   // index past the last register: writes to it must be dropped
   localparam logic [1:0] CsrSpare = 2'd3;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     start          = 1'b0;
   chan_type req_hue        = '0;
   chan_type req_saturation = '0;
   chan_type req_brightness = '0;
   logic     csr_we         = 1'b0;
   logic [1:0] csr_index    = '0;
   chan_type csr_wdata      = '0;

   logic     busy;
   logic     rsp_valid;
   chan_type rsp_red;
   chan_type rsp_green;
   chan_type rsp_blue;

   int       error_count;
   int       pending_count;
   int       pixel_count;

   int       idle_pct;          // chance in 100 that the sender idles a cycle
   int       sent_count;
   int       directed_count;
   int       watchdog;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   hsv_to_rgb_rainbow i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   hsvr_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .pixel_count    (pixel_count)
   );

   // Watchdog: any cycle that moves a request, a result or a register write
   // clears it; a hung block ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         watchdog <= 0;
      end else begin
         watchdog <= watchdog + 1;
         if (watchdog >= WatchdogLimit) begin
            $display("Watchdog expired after %0d idle cycles", WatchdogLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // One request: optional idle gap first, then start stays high until taken.
   // start only gets one assignment per edge, so back-to-back requests keep
   // it high without a glitch.
   task automatic send_pixel(input chan_type hue, input chan_type sat, input chan_type val);
      int gap;
      gap = 0;
      while (gap < MaxGap && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   // Stop sending and wait until every pixel in flight has come out.
   // The first edge lets the last accepted request show in pending_count.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Back-to-back writes keep csr_we high; the caller lowers it.
   task automatic csr_write(input logic [1:0] idx, input chan_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Register setting per random phase; extremes first, then random values, then reset values.
   // Unused upper bits of the one-bit registers carry random junk.
   task automatic load_setting(input int phase);
      logic     yellow, halve;
      chan_type gscale;
      case (phase)
         1:       begin yellow = 1'b1; halve = 1'b0; gscale = 8'd0;   end
         2:       begin yellow = 1'b0; halve = 1'b1; gscale = 8'd0;   end
         3:       begin yellow = 1'b1; halve = 1'b1; gscale = 8'd255; end
         4:       begin yellow = 1'b0; halve = 1'b0; gscale = 8'd1;   end
         5:       begin yellow = 1'($urandom); halve = 1'($urandom);
                        gscale = 8'($urandom); end
         6:       begin yellow = 1'b1; halve = 1'($urandom);
                        gscale = 8'($urandom_range(2, 254)); end
         default: begin yellow = 1'b0; halve = 1'b0; gscale = 8'd0;   end
      endcase
      csr_write(CSR_STRONG_YELLOW, {7'($urandom), yellow});
      csr_write(CsrSpare,          8'($urandom));
      csr_write(CSR_HALVE_GREEN,   {7'($urandom), halve});
      csr_write(CSR_GREEN_SCALE,   gscale);
      csr_we <= 1'b0;
   endtask

   // Saturation and brightness lean on the special values 0, 1, 2, 253, 254 and 255
   function automatic chan_type pick_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(1, 2));
         3:       return 8'($urandom_range(253, 254));
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      sent_count = 0;
      idle_pct   = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset register values.
      // Start and end of every hue section at full color.
      for (int sec = 0; sec < 8; sec++) begin
         send_pixel(8'(sec * 32), 8'd255, 8'd255);
         send_pixel(8'(sec * 32 + 31), 8'd255, 8'd255);
      end
      send_pixel(8'h40, 8'd0,   8'd255);  // no saturation: white
      send_pixel(8'h40, 8'd1,   8'd255);  // barely saturated
      send_pixel(8'hA5, 8'd254, 8'd255);  // nearly full color
      send_pixel(8'h10, 8'd255, 8'd0);    // black
      send_pixel(8'h10, 8'd255, 8'd1);    // dimmest nonzero level
      send_pixel(8'h10, 8'd255, 8'd254);  // just below full brightness
      send_pixel(8'h70, 8'd0,   8'd0);    // white dimmed to black
      send_pixel(8'hFF, 8'd128, 8'd128);  // half saturation, half value
      directed_count = sent_count;

      // Random phases, each with its own register setting and idle mix:
      // no gaps, sender idle 68 in 100, sender idle 15 in 100.
      for (int phase = 1; phase <= RandomPhases; phase++) begin
         wait_idle();
         load_setting(phase);
         case (phase % 3)
            0:       idle_pct = 15;
            1:       idle_pct = 0;
            default: idle_pct = 68;
         endcase
         for (int n = 0; n < PhaseItems; n++)
            send_pixel(8'($urandom), pick_level(), pick_level());
      end

      wait_idle();
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d requests (%0d directed) across %0d register settings, %0d pixels checked.",
               sent_count, directed_count, RandomPhases + 1, pixel_count);
      $display("Covered both yellow boosts, green halving, green scale 0..255, gaps of 0/15/68 pct.");
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== hsv_to_rgb_rainbow.f =====
rtl/hsvr_pkg.sv
rtl/hsv_to_rgb_rainbow.sv
rtl/hsvr_checker.sv
sim/hsvr_checker.sv
sim/tb_top.sv
